[rtl/core/scdiv_pkg.sv]
// shared types and constants for the serial clock divider search
// no dependencies
package scdiv_pkg;

    // width of the shared restoring divider (dividend, divisor, quotient)
    localparam int DIV_W = 33;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    localparam logic [7:0] PRESCALE_MIN   = 8'd2;
    localparam logic [7:0] PRESCALE_LIMIT = 8'd254;

    localparam logic [31:0] PCLK_RESET = 32'd60000000;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV1 = 7'b0000010,
        ST_SET2 = 7'b0000100,
        ST_DIV2 = 7'b0001000,
        ST_SET3 = 7'b0010000,
        ST_DIV3 = 7'b0100000,
        ST_FIN  = 7'b1000000
    } t_state;

endpackage

[rtl/core/spi_clock_divider_search.sv]
// serial clock prescale and divider search, top level
// depends on scdiv_pkg
//
// usage:
//   i_cfg_we / i_cfg_wdata write the peripheral clock rate (one register,
//   no read-back); write it only while busy is low and no search runs.
//   a command beat is taken at the clock edge where start is high and busy
//   is low; i_target_rate is sampled there.
//   the result (o_divider, o_prescale, o_unreachable) is shown for exactly
//   one cycle with o_valid high; the receiver cannot stall, so it must take
//   the beat in that cycle.
// shared divider:
//   one restoring divider, one quotient bit per cycle, is shared by three
//   divisions: clock / (target + 1), need / span and need / prescale, with a
//   set-up state (ST_SET2, ST_SET3) before the second and third.  a search
//   ends in ST_FIN, or early in ST_SET3 when the prescale saturates.  busy is
//   high for the whole search; a new start is taken in the cycle the strobe
//   is shown.
// reset:
//   synchronous, active low; returns to idle, drops the strobe and loads
//   the peripheral clock register with 60 MHz.
module spi_clock_divider_search #(
    parameter int DIVIDER_MAX = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    input  logic [31:0] i_target_rate,
    output logic        busy,
    output logic        o_valid,
    output logic [7:0]  o_divider,
    output logic [7:0]  o_prescale,
    output logic        o_unreachable
);

    localparam int W = scdiv_pkg::DIV_W;
    // number of dividers tried per prescale
    localparam logic [W-1:0] SPAN = W'(DIVIDER_MAX + 1);
    localparam logic [7:0] DIV_SAT = 8'(DIVIDER_MAX);

    scdiv_pkg::t_state r_state, n_state;

    logic [31:0] r_pclk;

    // shared divider: r_quo holds the dividend and shifts in quotient bits
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_quo, n_quo;
    logic [W-1:0] r_dvs, n_dvs;
    logic [scdiv_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // smallest divisor product that brings the rate to the target
    logic [W-1:0] r_need, n_need;
    logic [7:0]   r_pre, n_pre;

    logic       r_valid, n_valid;
    logic [7:0] r_divider, n_divider;
    logic [7:0] r_prescale, n_prescale;
    logic       r_unreach, n_unreach;

    // one divider step
    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] step_rem;
    logic [W-1:0] step_quo;

    // prescale rounding from the second quotient
    logic [W-1:0] p_min;
    logic [W-1:0] p_even;

    assign rem_sh   = {r_rem, r_quo[W-1]};
    assign diff     = rem_sh - {1'b0, r_dvs};
    assign ge       = rem_sh >= {1'b0, r_dvs};
    assign step_rem = ge ? diff[W-1:0] : rem_sh[W-1:0];
    assign step_quo = {r_quo[W-2:0], ge};

    assign p_min  = (r_quo < W'(scdiv_pkg::PRESCALE_MIN)) ? W'(scdiv_pkg::PRESCALE_MIN) : r_quo;
    assign p_even = p_min + W'(p_min[0]);

    always_comb begin
        n_state    = r_state;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dvs      = r_dvs;
        n_cnt      = r_cnt;
        n_need     = r_need;
        n_pre      = r_pre;
        n_valid    = 1'b0;
        n_divider  = r_divider;
        n_prescale = r_prescale;
        n_unreach  = r_unreach;

        case (r_state)
            scdiv_pkg::ST_IDLE: begin
                if (start) begin
                    // clock / (target + 1)
                    n_rem   = '0;
                    n_quo   = W'(r_pclk);
                    n_dvs   = W'(i_target_rate) + W'(1);
                    n_cnt   = '0;
                    n_state = scdiv_pkg::ST_DIV1;
                end
            end
            scdiv_pkg::ST_DIV1, scdiv_pkg::ST_DIV2, scdiv_pkg::ST_DIV3: begin
                n_rem = step_rem;
                n_quo = step_quo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == scdiv_pkg::CNT_LAST) begin
                    case (r_state)
                        scdiv_pkg::ST_DIV1: n_state = scdiv_pkg::ST_SET2;
                        scdiv_pkg::ST_DIV2: n_state = scdiv_pkg::ST_SET3;
                        default:            n_state = scdiv_pkg::ST_FIN;
                    endcase
                end
            end
            scdiv_pkg::ST_SET2: begin
                // ceil(need / span)
                n_need  = r_quo + W'(1);
                n_rem   = '0;
                n_quo   = r_quo + SPAN;
                n_dvs   = SPAN;
                n_cnt   = '0;
                n_state = scdiv_pkg::ST_DIV2;
            end
            scdiv_pkg::ST_SET3: begin
                if (p_even > W'(scdiv_pkg::PRESCALE_LIMIT)) begin
                    // no pair reaches the target
                    n_valid    = 1'b1;
                    n_divider  = DIV_SAT;
                    n_prescale = scdiv_pkg::PRESCALE_LIMIT;
                    n_unreach  = 1'b1;
                    n_state    = scdiv_pkg::ST_IDLE;
                end else begin
                    // ceil(need / prescale)
                    n_pre   = p_even[7:0];
                    n_rem   = '0;
                    n_quo   = r_need + p_even - W'(1);
                    n_dvs   = p_even;
                    n_cnt   = '0;
                    n_state = scdiv_pkg::ST_DIV3;
                end
            end
            scdiv_pkg::ST_FIN: begin
                // quotient is at least one since need is never zero
                n_valid    = 1'b1;
                n_divider  = r_quo[7:0] - 8'd1;
                n_prescale = r_pre;
                n_unreach  = 1'b0;
                n_state    = scdiv_pkg::ST_IDLE;
            end
            default: begin
                n_state = scdiv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scdiv_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_pclk  <= scdiv_pkg::PCLK_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_pclk <= i_cfg_wdata;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dvs      <= n_dvs;
        r_cnt      <= n_cnt;
        r_need     <= n_need;
        r_pre      <= n_pre;
        r_divider  <= n_divider;
        r_prescale <= n_prescale;
        r_unreach  <= n_unreach;
    end

    assign busy          = (r_state != scdiv_pkg::ST_IDLE);
    assign o_valid       = r_valid;
    assign o_divider     = r_divider;
    assign o_prescale    = r_prescale;
    assign o_unreachable = r_unreach;

endmodule
